@@ sv/attribute_name_scanner_assert.svh @@
// Assertion helpers for the attribute name scanner
`ifndef ATTRIBUTE_NAME_SCANNER_ASSERT_SVH
`define ATTRIBUTE_NAME_SCANNER_ASSERT_SVH

// same-cycle implication
`define ASN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("asn assertion failed");

// next-cycle implication
`define ASN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("asn assertion failed");

`endif

@@ sv/asn_pkg.sv @@
package asn_pkg;

  localparam int NAME_MAX = 16;
  localparam int POS_BITS = 16;
  localparam int LEN_BITS = $clog2(NAME_MAX + 1);
  localparam int IDX_BITS = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
  localparam int OFFSET_BITS = 16;
  localparam int CFG_DATA_BITS = 64;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_EQ  = 8'h3D;
  localparam logic [7:0] CH_DQ  = 8'h22;
  localparam logic [7:0] CH_SQ  = 8'h27;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_NAME_LOW  = 2'd0,
    REG_NAME_HIGH = 2'd1,
    REG_NAME_LEN  = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    MODE_START   = 3'd0,
    MODE_MATCH   = 3'd1,
    MODE_DQUOTE  = 3'd2,
    MODE_SQUOTE  = 3'd3,
    MODE_NOMATCH = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_SCAN     = 2'd0,
    ST_FOUND    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_IGNORED  = 2'd3
  } status_t;

  typedef struct packed {
    logic [NAME_MAX-1:0][7:0] chars;
    logic [LEN_BITS-1:0]      len;
  } name_cfg_t;

  typedef struct packed {
    status_t                 status;
    logic [OFFSET_BITS-1:0]  offset;
  } scan_result_t;

endpackage

@@ sv/asn_cfg.sv @@
module asn_cfg
  import asn_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output name_cfg_t                name_cfg
);

  logic [63:0] name_low;
  logic [63:0] name_high;
  logic [4:0]  name_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      name_low    <= '0;
      name_high   <= '0;
      name_length <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NAME_LOW:  name_low    <= cfg_data;
        REG_NAME_HIGH: name_high   <= cfg_data;
        REG_NAME_LEN:  name_length <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    name_cfg.chars = {name_high, name_low};
    if (32'(name_length) > NAME_MAX) begin
      name_cfg.len = LEN_BITS'(NAME_MAX);
    end else begin
      name_cfg.len = LEN_BITS'(name_length);
    end
  end

endmodule

@@ sv/asn_core.sv @@
module asn_core
  import asn_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic         first,
  input  logic [7:0]   ch,
  input  name_cfg_t    name_cfg,
  output scan_result_t result
);

  `include "attribute_name_scanner_assert.svh"

  mode_t               mode, mode_cur, mode_next;
  logic [IDX_BITS-1:0] match_index, idx_cur, match_index_next;
  logic                decided, dec_cur, decided_next;
  logic [POS_BITS-1:0] byte_position, pos_cur, byte_position_next;
  logic [LEN_BITS-1:0] idx_inc;
  logic                name_done;

  function automatic mode_t token_mode(input logic [7:0] c);
    if (c == CH_SP || c == CH_TAB) begin
      return MODE_START;
    end else if (c == CH_DQ) begin
      return MODE_DQUOTE;
    end else if (c == CH_SQ) begin
      return MODE_SQUOTE;
    end else begin
      return MODE_NOMATCH;
    end
  endfunction

  // a first byte restarts the scan before this byte is looked at
  assign mode_cur  = first ? MODE_START : mode;
  assign idx_cur   = first ? '0 : match_index;
  assign dec_cur   = first ? 1'b0 : decided;
  assign pos_cur   = first ? '0 : byte_position;
  assign idx_inc   = LEN_BITS'(idx_cur) + LEN_BITS'(1);
  assign name_done = (idx_inc >= name_cfg.len);

  assign byte_position_next = (pos_cur == POS_MAX) ? pos_cur : pos_cur + POS_BITS'(1);

  always_comb begin
    mode_next        = mode_cur;
    match_index_next = idx_cur;
    decided_next     = dec_cur;
    if (!dec_cur) begin
      if (ch == CH_NUL) begin
        decided_next = 1'b1;
      end else begin
        unique case (mode_cur)
          MODE_MATCH: begin
            if (name_done) begin
              decided_next = 1'b1;
            end else if (ch == name_cfg.chars[idx_inc[IDX_BITS-1:0]]) begin
              match_index_next = idx_inc[IDX_BITS-1:0];
            end else begin
              mode_next = token_mode(ch);
            end
          end
          MODE_DQUOTE: begin
            if (ch == CH_DQ) mode_next = MODE_NOMATCH;
          end
          MODE_SQUOTE: begin
            if (ch == CH_SQ) mode_next = MODE_NOMATCH;
          end
          MODE_NOMATCH: begin
            mode_next = token_mode(ch);
          end
          default: begin
            if (name_cfg.len != '0 && ch == name_cfg.chars[0]) begin
              mode_next        = MODE_MATCH;
              match_index_next = '0;
            end else begin
              mode_next = token_mode(ch);
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    result.status = ST_SCAN;
    result.offset = '0;
    if (dec_cur) begin
      result.status = ST_IGNORED;
    end else if (ch == CH_NUL) begin
      result.status = ST_NOTFOUND;
    end else if (mode_cur == MODE_MATCH && name_done) begin
      if (ch == CH_EQ) begin
        result.status = ST_FOUND;
        // offset of the byte after '=' is the saturated next position
        if (32'(byte_position_next) > 32'hFFFF) begin
          result.offset = '1;
        end else begin
          result.offset = OFFSET_BITS'(byte_position_next);
        end
      end else begin
        result.status = ST_NOTFOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_START;
      match_index   <= '0;
      decided       <= 1'b0;
      byte_position <= '0;
    end else if (step) begin
      mode          <= mode_next;
      match_index   <= match_index_next;
      decided       <= decided_next;
      byte_position <= byte_position_next;
    end
  end

  `ASN_ASSERT_NEXT(a_decided_holds, step && decided && !first, decided)
  `ASN_ASSERT_NEXT(a_pos_saturates, step && !first && byte_position == POS_MAX,
                   byte_position == POS_MAX)

endmodule

@@ sv/attribute_name_scanner.sv @@
// An input transaction goes through the input register, then the result register, to its result.
// Throughput: one byte per cycle when the output is not stalled; the scan state updates once per byte.
// Input side stays ready while a result waits, as long as the input register is free.
// Reset (rst, synchronous, active high): scan restarts at position 0, both stages empty,
// name registers and name length cleared.
module attribute_name_scanner
  import asn_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [7:0]               s_tdata,   // [7:0] text_byte
  input  logic                     s_tuser,   // [0] first_byte
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [15:0]              m_tdata,   // [15:0] value_offset
  output logic [1:0]               m_tuser    // [1:0] scan_status
);

  `include "attribute_name_scanner_assert.svh"

  name_cfg_t    name_cfg;
  scan_result_t result;
  logic         in_valid;
  logic         first_q;
  logic [7:0]   byte_q;
  logic         out_adv;
  logic         step;

  assign out_adv  = !m_tvalid || m_tready;
  assign step     = in_valid && out_adv;
  assign s_tready = !in_valid || out_adv;

  asn_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .name_cfg  (name_cfg)
  );

  asn_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .first    (first_q),
    .ch       (byte_q),
    .name_cfg (name_cfg),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      first_q <= s_tuser;
      byte_q  <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_adv) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tuser <= result.status;
      m_tdata <= result.offset;
    end
  end

  `ASN_ASSERT_NOW(a_found_offset, m_tvalid && m_tuser == ST_FOUND, m_tdata != '0)
  `ASN_ASSERT_NOW(a_other_offset, m_tvalid && m_tuser != ST_FOUND, m_tdata == '0)

endmodule

@@ bench/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import asn_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic       first;
    logic [7:0] text;
  } text_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [7:0]               s_tdata = '0;   // [7:0] text_byte
  logic                     s_tuser = 1'b0; // [0] first_byte
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [15:0]              m_tdata;        // [15:0] value_offset
  logic [1:0]               m_tuser;        // [1:0] scan_status

  // name registers as the scanner sees them
  logic [127:0] name_chars = '0;
  logic [4:0]   name_len = '0;

  // scan state tracked alongside the block
  mode_t         scan_mode = MODE_START;
  int            match_pos = 0;
  logic          scan_decided = 1'b0;
  logic [15:0]   byte_pos = '0;

  text_beat_t    pending_bytes[$];
  scan_result_t  expected_results[$];
  text_beat_t    on_bus;
  scan_result_t  want;

  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  int error_count = 0;
  int cycle_count = 0;
  logic hold_req = 1'b0;
  logic rx_hold = 1'b0;

  attribute_name_scanner uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int name_used();
    return (name_len > NAME_MAX) ? NAME_MAX : int'(name_len);
  endfunction

  function automatic logic [7:0] name_at(int idx);
    return name_chars[idx*8 +: 8];
  endfunction

  function automatic mode_t mode_after_miss(logic [7:0] ch);
    if (ch == CH_SP || ch == CH_TAB) return MODE_START;
    if (ch == CH_DQ) return MODE_DQUOTE;
    if (ch == CH_SQ) return MODE_SQUOTE;
    return MODE_NOMATCH;
  endfunction

  task automatic predict_scan(text_beat_t b);
    scan_result_t r;
    int nxt;
    logic miss;
    r.status = ST_SCAN;
    r.offset = '0;
    miss = 1'b0;
    if (b.first) begin
      scan_mode = MODE_START;
      match_pos = 0;
      scan_decided = 1'b0;
      byte_pos = '0;
    end
    if (scan_decided) begin
      r.status = ST_IGNORED;
    end else if (b.text == CH_NUL) begin
      r.status = ST_NOTFOUND;
      scan_decided = 1'b1;
    end else begin
      case (scan_mode)
        MODE_MATCH: begin
          nxt = match_pos + 1;
          if (nxt >= name_used()) begin
            scan_decided = 1'b1;
            if (b.text == CH_EQ) begin
              r.status = ST_FOUND;
              r.offset = (byte_pos == POS_MAX) ? POS_MAX : byte_pos + 16'd1;
            end else begin
              r.status = ST_NOTFOUND;
            end
          end else if (b.text == name_at(nxt)) begin
            match_pos = nxt;
          end else begin
            miss = 1'b1;
          end
        end
        MODE_DQUOTE: if (b.text == CH_DQ) scan_mode = MODE_NOMATCH;
        MODE_SQUOTE: if (b.text == CH_SQ) scan_mode = MODE_NOMATCH;
        MODE_NOMATCH: miss = 1'b1;
        default: begin
          if (name_used() > 0 && b.text == name_at(0)) begin
            scan_mode = MODE_MATCH;
            match_pos = 0;
          end else begin
            miss = 1'b1;
          end
        end
      endcase
      if (miss) scan_mode = mode_after_miss(b.text);
    end
    if (byte_pos != POS_MAX) byte_pos = byte_pos + 16'd1;
    expected_results.push_back(r);
  endtask

  task automatic log_error(string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_scan(on_bus);
      if (!s_tvalid || s_tready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          on_bus = pending_bytes.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= on_bus.text;
          s_tuser <= on_bus.first;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          log_error($sformatf("unexpected result: status %0d offset %0d", m_tuser, m_tdata));
        end else begin
          want = expected_results.pop_front();
          if (m_tuser !== want.status || m_tdata !== want.offset)
            log_error($sformatf("status exp %0d got %0d, offset exp %0d got %0d",
                                want.status, m_tuser, want.offset, m_tdata));
        end
      end
      m_tready <= !rx_hold && ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // long receiver hold-off, so the input side backs up
  initial begin
    wait (hold_req);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (200) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic set_name(logic [63:0] lo, logic [63:0] hi, logic [4:0] len);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_NAME_LOW;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= REG_NAME_HIGH;
    cfg_data <= hi;
    @(posedge clk);
    cfg_index <= REG_NAME_LEN;
    cfg_data <= 64'(len);
    @(posedge clk);
    cfg_we <= 1'b0;
    name_chars = {hi, lo};
    name_len = len;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || s_tvalid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    for (int k = 0; k < 8; k++) w[k*8 +: 8] = 8'($urandom_range(33, 126));
    return w;
  endfunction

  function automatic logic [7:0] pick_char();
    int roll;
    int n;
    roll = $urandom_range(0, 9);
    n = name_used();
    if (roll < 4 && n > 0) return name_at($urandom_range(0, n - 1));
    if (roll == 4) return CH_EQ;
    if (roll == 5) return CH_DQ;
    if (roll == 6) return CH_SQ;
    if (roll == 7) return ($urandom_range(0, 1) != 0) ? CH_SP : CH_TAB;
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic push_text(string s, logic first);
    for (int k = 0; k < s.len(); k++)
      pending_bytes.push_back(text_beat_t'{first: first && (k == 0), text: s[k]});
  endtask

  // mostly well-formed attribute strings: tokens, quoted spans, name hits and near misses
  task automatic push_random_text(int count);
    logic [7:0] str_q[$];
    logic [7:0] q;
    int added;
    int n;
    int kind;
    int cut;
    added = 0;
    n = name_used();
    while (added < count) begin
      str_q.delete();
      repeat ($urandom_range(1, 4)) begin
        if (str_q.size() != 0 && $urandom_range(0, 3) != 0)
          str_q.push_back(($urandom_range(0, 1) != 0) ? CH_SP : CH_TAB);
        kind = $urandom_range(0, 9);
        case (kind)
          3: begin
            for (int k = 0; k < n; k++) str_q.push_back(name_at(k));
            str_q.push_back(pick_char());
          end
          4: begin
            cut = (n > 0) ? $urandom_range(0, n - 1) : 0;
            for (int k = 0; k < cut; k++) str_q.push_back(name_at(k));
            str_q.push_back(pick_char());
          end
          5: begin
            q = ($urandom_range(0, 1) != 0) ? CH_DQ : CH_SQ;
            str_q.push_back(q);
            repeat ($urandom_range(0, 6)) str_q.push_back(pick_char());
            for (int k = 0; k < n; k++) str_q.push_back(name_at(k));
            str_q.push_back(CH_EQ);
            str_q.push_back(q);
          end
          6: repeat ($urandom_range(1, 3)) str_q.push_back(8'($urandom_range(0, 255)));
          7: begin
            str_q.push_back(8'($urandom_range(33, 126)));
            for (int k = 0; k < n; k++) str_q.push_back(name_at(k));
            str_q.push_back(CH_EQ);
          end
          8: repeat ($urandom_range(1, 3)) str_q.push_back(CH_SP);
          default: begin
            for (int k = 0; k < n; k++) str_q.push_back(name_at(k));
            str_q.push_back(CH_EQ);
            repeat ($urandom_range(0, 3)) str_q.push_back(8'($urandom_range(33, 126)));
          end
        endcase
      end
      if ($urandom_range(0, 1) != 0) str_q.push_back(CH_NUL);
      if ($urandom_range(0, 4) == 0) str_q.push_back(pick_char());
      foreach (str_q[k])
        pending_bytes.push_back(text_beat_t'{
          first: (k == 0) && ($urandom_range(0, 9) != 0), text: str_q[k]});
      added += str_q.size();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_gap_pct = 18;
    recv_gap_pct = 79;
    set_name(64'h6469, '0, 5'd2);
    push_text("id=x", 1'b0);
    push_text("a'id=' id=", 1'b1);
    push_text("idx", 1'b1);
    push_text("i", 1'b1);
    pending_bytes.push_back(text_beat_t'{first: 1'b0, text: CH_NUL});
    push_text("\"=\"id=", 1'b1);
    pending_bytes.push_back(text_beat_t'{first: 1'b0, text: CH_NUL});
    push_random_text(70);
    wait_idle();
    set_name(rand64(), rand64(), 5'd0);
    push_random_text(60);
    wait_idle();
    set_name(rand_word(), '0, 5'd1);
    push_random_text(80);
    wait_idle();

    send_gap_pct = 79;
    recv_gap_pct = 18;
    set_name(rand_word(), rand_word(), 5'd16);
    push_random_text(90);
    wait_idle();
    set_name('1, '1, 5'd31);
    push_random_text(60);
    wait_idle();
    set_name(64'h0000_0000_0062_0061, rand64(), 5'd3);
    push_random_text(60);
    wait_idle();

    send_gap_pct = 0;
    recv_gap_pct = 0;
    set_name(rand_word(), rand_word(), 5'd17);
    push_random_text(120);
    hold_req = 1'b1;
    wait_idle();
    set_name(rand_word(), '0, 5'd5);
    push_random_text(80);
    wait_idle();

    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
